FILE: hdl/sorted_unique_list_assert.svh
// ----------------------------------------------------------------------------
// sorted_unique_list_assert.svh
// Assertion macros used by the sorted unique list RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_LIST_ASSERT_SVH
`define SORTED_UNIQUE_LIST_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SUL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SUL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sul_pkg.sv
// ----------------------------------------------------------------------------
// sul_pkg
// Shared types and constants of the sorted unique list.
// ----------------------------------------------------------------------------
package sul_pkg;

	// Default number of entries held by the list.
	localparam int CAPACITY_DEF = 8;

	// Fixed field widths.
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;

	// Operation codes.
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_DEL = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESULT
	} state_t;

endpackage

FILE: hdl/sorted_unique_list.sv
// ----------------------------------------------------------------------------
// sorted_unique_list
// Fixed-capacity set of signed 32-bit values kept in ascending order.
//
// Usage: an input item (op, value) is taken on in_valid with in_stall low.
// op 0 adds the value, op 1 deletes it. Every item yields one result item
// (status, count) on out_valid, held until out_stall is low.
// The entries live in a RAM with one read and one write port. An item scans
// the held entries in order, one entry per clock, reading ahead while the
// entry just read is moved up (add) or down (delete) one place behind it.
// With n entries held, an item reads them all in order before its result
// enters the output register, and the next item is accepted the cycle
// after. An add to an empty list reads no entry and writes the value at
// address 0; a refused add to a full list or a delete from an empty list
// skips the scan. A duplicate add ends the scan at the matching entry.
// The output register lets the next item be accepted while a result waits;
// a stalled result only holds back the end of the following item.
// Reset clears the count and all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sorted_unique_list_assert.svh"

module sorted_unique_list #(
	parameter int CAPACITY = sul_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [sul_pkg::DATA_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sul_pkg::STATUS_W-1:0]        status,
	output logic [sul_pkg::COUNT_W-1:0]         count
);
	import sul_pkg::*;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	state_t state_q, state_d;

	// Item registers.
	logic                     op_q;
	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] carry_q;
	logic                     hit_q;
	status_t                  res_st_q;

	// List length and scan position.
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_idx_s1;

	// Output register.
	logic                out_valid_q;
	status_t             status_q;
	logic [COUNT_W-1:0]  count_q;

	// Memory ports.
	logic                     rd_en;
	logic signed [DATA_W-1:0] rd_data;
	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	logic signed [DATA_W-1:0] wr_data;

	// Scan decode.
	logic in_take;
	logic refuse;
	logic rd_more;
	logic proc_s1;
	logic data_eq;
	logic data_gt;
	logic dup_hit;
	logic scan_end;
	logic out_free;

	sul_ram #(
		.DEPTH  (CAPACITY),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// Conditions shared by the sequencer and the datapath.
	always_comb begin
		in_take  = (state_q == S_IDLE) && in_valid;
		refuse   = ((op == OP_ADD) && (cnt_q >= CNT_W'(CAPACITY))) ||
			((op == OP_DEL) && (cnt_q == '0));
		rd_more  = rd_idx_q < cnt_q;
		proc_s1  = (state_q == S_SCAN) && rd_vld_s1;
		data_eq  = rd_data == value_q;
		data_gt  = rd_data > value_q;
		dup_hit  = proc_s1 && (op_q == OP_ADD) && !hit_q && data_eq;
		scan_end = (state_q == S_SCAN) && !rd_more && !rd_vld_s1;
		out_free = !out_valid_q || !out_stall;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = refuse ? S_RESULT : S_SCAN;
				end
			end
			S_SCAN: begin
				if (dup_hit || scan_end) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs: handshake, memory reads and writes.
	always_comb begin
		in_stall = (state_q != S_IDLE);
		rd_en    = (state_q == S_SCAN) && rd_more && !dup_hit;
		wr_en    = 1'b0;
		wr_addr  = rd_idx_s1;
		wr_data  = carry_q;
		if (proc_s1) begin
			if (op_q == OP_ADD) begin
				if (hit_q) begin
					wr_en = 1'b1;
				end else if (!data_eq && data_gt) begin
					wr_en   = 1'b1;
					wr_data = value_q;
				end
			end else if (hit_q) begin
				// Close the gap: the entry just read moves down one place.
				wr_en   = 1'b1;
				wr_addr = rd_idx_s1 - ADDR_W'(1);
				wr_data = rd_data;
			end
		end
		if (scan_end && (op_q == OP_ADD)) begin
			// The last entry moved, or the new value, lands at the top.
			wr_en   = 1'b1;
			wr_addr = cnt_q[ADDR_W-1:0];
			wr_data = hit_q ? carry_q : value_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (in_take) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
			end
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (proc_s1 && !hit_q) begin
				if (op_q == OP_ADD) begin
					hit_q <= !data_eq && data_gt;
				end else begin
					hit_q <= data_eq;
				end
			end
			if (scan_end) begin
				if (op_q == OP_ADD) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (hit_q) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			if ((state_q == S_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q    <= op;
			value_q <= value;
			if ((op == OP_ADD) && refuse) begin
				res_st_q <= ST_FULL;
			end else if (refuse) begin
				res_st_q <= ST_EMPTY;
			end else begin
				res_st_q <= ST_OK;
			end
		end
		if (rd_en) begin
			rd_idx_s1 <= rd_idx_q[ADDR_W-1:0];
		end
		if (proc_s1 && (op_q == OP_ADD) && (hit_q || (!data_eq && data_gt))) begin
			carry_q <= rd_data;
		end
		if (dup_hit) begin
			res_st_q <= ST_DUP;
		end
		if (scan_end && (op_q == OP_DEL) && !hit_q) begin
			res_st_q <= ST_NOTFOUND;
		end
		if ((state_q == S_RESULT) && out_free) begin
			status_q <= res_st_q;
			count_q  <= COUNT_W'(cnt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign count     = count_q;

	// Checks on the list length, the write address and the scan index.
	`SUL_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
	`SUL_ASSERT_IMP(a_wr_range, wr_en, {1'b0, wr_addr} <= {1'b0, cnt_q}, "write beyond list end")
	`SUL_ASSERT_NXT(a_cnt_hold, state_q != S_SCAN, $stable(cnt_q), "count moved outside a scan")
	`SUL_ASSERT_IMP(a_scan_bound, state_q == S_SCAN, rd_idx_q <= cnt_q, "scan ran past list end")

endmodule

FILE: hdl/sul_ram.sv
// ----------------------------------------------------------------------------
// sul_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sul_ram #(
	parameter int DEPTH  = sul_pkg::CAPACITY_DEF,
	parameter int ADDR_W = 3
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [ADDR_W-1:0]                 wr_addr,
	input  logic signed [sul_pkg::DATA_W-1:0] wr_data,
	input  logic                              rd_en,
	input  logic [ADDR_W-1:0]                 rd_addr,
	output logic signed [sul_pkg::DATA_W-1:0] rd_data
);
	import sul_pkg::*;

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
